// ===== rtl/core/email_address_syntax_checker_unit_defines.svh =====
// ----------------------------------------------------------------------------
// email address syntax checker assertion macros
// shared assertion forms for the checker rtl
// ----------------------------------------------------------------------------
`ifndef EMAIL_ADDRESS_SYNTAX_CHECKER_UNIT_DEFINES_SVH
`define EMAIL_ADDRESS_SYNTAX_CHECKER_UNIT_DEFINES_SVH

// same-cycle implication
`define ESC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ESC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/esc_pkg.sv =====
// ----------------------------------------------------------------------------
// esc_pkg
// types, codes and character sets of the email address syntax checker
// ----------------------------------------------------------------------------
`default_nettype none

package esc_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CFG_IDX_W = 8;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_LOCAL_MAX = cfg_idx_t'(0);
  localparam cfg_idx_t CFG_DOMAIN_MAX = cfg_idx_t'(1);

  localparam byte_t LOCAL_MAX_RST = byte_t'(64);
  localparam byte_t DOMAIN_MAX_RST = byte_t'(63);

  localparam byte_t CH_AT = 8'h40;
  localparam byte_t CH_DOT = 8'h2E;
  localparam byte_t CH_HYPHEN = 8'h2D;

  typedef struct packed {
    logic is_at;
    logic is_dot;
    logic local_ok;
    logic domain_ok;
  } char_class_t;

  function automatic logic is_alnum(input byte_t c);
    return (c inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39]});
  endfunction

  function automatic logic is_local_extra(input byte_t c);
    return (c inside {8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B,
                      8'h2D, 8'h2F, 8'h3D, 8'h3F, 8'h5E, 8'h5F, 8'h60, 8'h7B,
                      8'h7C, 8'h7D, 8'h7E, 8'h2E});
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/esc_classify.sv =====
// ----------------------------------------------------------------------------
// esc_classify
// sorts one address byte into the character classes the rules need
// ----------------------------------------------------------------------------
`default_nettype none

module esc_classify (
  input  wire esc_pkg::byte_t      ch,
  output esc_pkg::char_class_t     ch_class
);

  always_comb begin
    ch_class.is_at     = (ch == esc_pkg::CH_AT);
    ch_class.is_dot    = (ch == esc_pkg::CH_DOT);
    ch_class.local_ok  = esc_pkg::is_alnum(ch) || esc_pkg::is_local_extra(ch);
    ch_class.domain_ok = esc_pkg::is_alnum(ch) || (ch == esc_pkg::CH_HYPHEN) ||
                         (ch == esc_pkg::CH_DOT);
  end

endmodule

`default_nettype wire

// ===== rtl/core/esc_track.sv =====
// ----------------------------------------------------------------------------
// esc_track
// per-address state: at sign, part lengths, dot memory and failure flag
// ----------------------------------------------------------------------------
`default_nettype none
`include "email_address_syntax_checker_unit_defines.svh"

module esc_track (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       step,
  input  wire                       last,
  input  wire esc_pkg::char_class_t ch_class,
  input  wire esc_pkg::byte_t       local_max,
  input  wire esc_pkg::byte_t       domain_max,
  output logic                      result_ok
);

  logic           seen_at_r, seen_at_nxt;
  logic           prev_dot_r, prev_dot_nxt;
  logic           failed_r, failed_nxt;
  esc_pkg::byte_t local_cnt_r, local_cnt_nxt;
  esc_pkg::byte_t domain_cnt_r, domain_cnt_nxt;

  always_comb begin
    seen_at_nxt    = seen_at_r;
    prev_dot_nxt   = prev_dot_r;
    failed_nxt     = failed_r;
    local_cnt_nxt  = local_cnt_r;
    domain_cnt_nxt = domain_cnt_r;
    if (ch_class.is_at) begin
      if (seen_at_r || (local_cnt_r == '0)) begin
        failed_nxt = 1'b1;
      end
      seen_at_nxt  = 1'b1;
      prev_dot_nxt = 1'b0;
    end else if (!seen_at_r) begin
      if (!ch_class.local_ok) begin
        failed_nxt = 1'b1;
      end
      if (ch_class.is_dot && ((local_cnt_r == '0) || prev_dot_r)) begin
        failed_nxt = 1'b1;
      end
      if (local_cnt_r >= local_max) begin
        failed_nxt = 1'b1;
      end else begin
        local_cnt_nxt = local_cnt_r + 8'd1;
      end
      prev_dot_nxt = ch_class.is_dot;
    end else begin
      if (!ch_class.domain_ok) begin
        failed_nxt = 1'b1;
      end
      if (ch_class.is_dot && prev_dot_r) begin
        failed_nxt = 1'b1;
      end
      if (domain_cnt_r >= domain_max) begin
        failed_nxt = 1'b1;
      end else begin
        domain_cnt_nxt = domain_cnt_r + 8'd1;
      end
      prev_dot_nxt = ch_class.is_dot;
    end
  end

  assign result_ok = !failed_nxt && seen_at_nxt && (local_cnt_nxt != '0) &&
                     (domain_cnt_nxt != '0) && !prev_dot_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_at_r    <= 1'b0;
      prev_dot_r   <= 1'b0;
      failed_r     <= 1'b0;
      local_cnt_r  <= '0;
      domain_cnt_r <= '0;
    end else if (step) begin
      if (last) begin
        seen_at_r    <= 1'b0;
        prev_dot_r   <= 1'b0;
        failed_r     <= 1'b0;
        local_cnt_r  <= '0;
        domain_cnt_r <= '0;
      end else begin
        seen_at_r    <= seen_at_nxt;
        prev_dot_r   <= prev_dot_nxt;
        failed_r     <= failed_nxt;
        local_cnt_r  <= local_cnt_nxt;
        domain_cnt_r <= domain_cnt_nxt;
      end
    end
  end

  `ESC_ASSERT_NEXT(a_clear_after_last, clk, rst_n, step && last,
    !seen_at_r && !failed_r && (local_cnt_r == '0) && (domain_cnt_r == '0),
    "state not cleared after last beat")
  `ESC_ASSERT_NOW(a_domain_needs_at, clk, rst_n, domain_cnt_r != '0, seen_at_r,
    "domain bytes counted without an at sign")
  `ESC_ASSERT_NEXT(a_at_clears_dot, clk, rst_n, step && !last && ch_class.is_at,
    seen_at_r && !prev_dot_r, "at sign did not clear dot memory")
  `ESC_ASSERT_NEXT(a_fail_sticky, clk, rst_n, step && !last && failed_r, failed_r,
    "failure flag dropped inside an address")

endmodule

`default_nettype wire

// ===== rtl/core/email_address_syntax_checker_unit.sv =====
// a last beat's verdict is registered in the result register and shows on out_
// throughput: one byte per cycle via the single input stage and result register;
// a last beat holds the input stage until the result register is empty or taken
// reset: synchronous active-low rst_n clears all address state and valid flags
// reset: local_max returns to 64 and domain_max to 63
// ----------------------------------------------------------------------------
// email_address_syntax_checker_unit
// checks a byte stream address for email syntax, one verdict per last beat
// ----------------------------------------------------------------------------
`default_nettype none

module email_address_syntax_checker_unit (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire esc_pkg::byte_t   in_ch,
  input  wire                   in_last,
  output logic                  out_valid,
  input  wire                   out_ready,
  output logic                  out_valid_res,
  input  wire                   cfg_valid,
  output logic                  cfg_ready,
  input  wire esc_pkg::cfg_idx_t cfg_index,
  input  wire esc_pkg::byte_t   cfg_wdata
);

  esc_pkg::byte_t       local_max_r;
  esc_pkg::byte_t       domain_max_r;
  logic                 s1_valid_r;
  esc_pkg::byte_t       s1_ch_r;
  logic                 s1_last_r;
  logic                 out_valid_r;
  logic                 out_res_r;
  logic                 s1_adv;
  logic                 result_ok;
  esc_pkg::char_class_t ch_class;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_max_r  <= esc_pkg::LOCAL_MAX_RST;
      domain_max_r <= esc_pkg::DOMAIN_MAX_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        esc_pkg::CFG_LOCAL_MAX:  local_max_r  <= cfg_wdata;
        esc_pkg::CFG_DOMAIN_MAX: domain_max_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // a non-last beat never needs the result slot
  assign s1_adv   = s1_valid_r && (!s1_last_r || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_ch_r   <= in_ch;
      s1_last_r <= in_last;
    end
  end

  esc_classify u_classify (
    .ch       (s1_ch_r),
    .ch_class (ch_class)
  );

  esc_track u_track (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (s1_adv),
    .last       (s1_last_r),
    .ch_class   (ch_class),
    .local_max  (local_max_r),
    .domain_max (domain_max_r),
    .result_ok  (result_ok)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_r) begin
      out_res_r <= result_ok;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_valid_res = out_res_r;

endmodule

`default_nettype wire

// ===== verif/address_verdict_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// address verdict checker
// follows the byte, result and register channels of the email address syntax
// checker, keeps its own copy of the address rules and the two length
// limits, and compares every verdict beat with the oldest predicted verdict
// ----------------------------------------------------------------------------
module address_verdict_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  esc_pkg::byte_t    in_ch,
  input  logic              in_last,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic              out_valid_res,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  esc_pkg::cfg_idx_t cfg_index,
  input  esc_pkg::byte_t    cfg_wdata,
  output int                mismatches,
  output int                pending,
  output int                verdicts,
  output int                valid_verdicts
);

  localparam esc_pkg::byte_t CH_BACKTICK = 8'h60;

  esc_pkg::byte_t local_lim;
  esc_pkg::byte_t domain_lim;
  esc_pkg::byte_t local_len;
  esc_pkg::byte_t domain_len;
  logic at_seen;
  logic prev_dot;
  logic broken;
  logic want;
  logic expected_verdicts[$];

  function automatic logic letter_or_digit(input esc_pkg::byte_t c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || (c >= "0" && c <= "9");
  endfunction

  function automatic logic local_byte_ok(input esc_pkg::byte_t c);
    if (letter_or_digit(c)) return 1'b1;
    case (c)
      "!", "#", "$", "%", "&", "'", "*", "+", "-", "/", "=", "?", "^", "_",
      CH_BACKTICK, "{", "|", "}", "~", esc_pkg::CH_DOT: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic domain_byte_ok(input esc_pkg::byte_t c);
    return letter_or_digit(c) || c == esc_pkg::CH_HYPHEN || c == esc_pkg::CH_DOT;
  endfunction

  task automatic clear_address;
    at_seen = 1'b0;
    local_len = '0;
    domain_len = '0;
    prev_dot = 1'b0;
    broken = 1'b0;
  endtask

  task automatic scan_byte(input esc_pkg::byte_t c, input logic fin);
    logic is_dot;
    is_dot = (c == esc_pkg::CH_DOT);
    if (c == esc_pkg::CH_AT) begin
      if (at_seen || local_len == 0) broken = 1'b1;
      at_seen = 1'b1;
      prev_dot = 1'b0;
    end else if (!at_seen) begin
      if (!local_byte_ok(c)) broken = 1'b1;
      if (is_dot && (local_len == 0 || prev_dot)) broken = 1'b1;
      if (local_len >= local_lim) broken = 1'b1;
      else local_len = local_len + 1'b1;
      prev_dot = is_dot;
    end else begin
      if (!domain_byte_ok(c)) broken = 1'b1;
      if (is_dot && prev_dot) broken = 1'b1;
      if (domain_len >= domain_lim) broken = 1'b1;
      else domain_len = domain_len + 1'b1;
      prev_dot = is_dot;
    end
    if (fin) begin
      expected_verdicts.push_back(!broken && at_seen && local_len != 0 &&
                                  domain_len != 0 && !prev_dot);
      clear_address();
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      local_lim = esc_pkg::LOCAL_MAX_RST;
      domain_lim = esc_pkg::DOMAIN_MAX_RST;
      clear_address();
      expected_verdicts.delete();
      mismatches = 0;
      verdicts = 0;
      valid_verdicts = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_verdicts.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: verdict beat with nothing pending, valid_res %0b",
                     $realtime, out_valid_res);
          mismatches++;
        end else begin
          want = expected_verdicts.pop_front();
          verdicts++;
          if (want) valid_verdicts++;
          if (out_valid_res !== want) begin
            if (mismatches < 10)
              $display("%0t: verdict %0d valid_res expected %0b got %0b",
                       $realtime, verdicts, want, out_valid_res);
            mismatches++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          esc_pkg::CFG_LOCAL_MAX:  local_lim = cfg_wdata;
          esc_pkg::CFG_DOMAIN_MAX: domain_lim = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready) scan_byte(in_ch, in_last);
    end
    pending = expected_verdicts.size();
  end

endmodule

// ===== verif/tb_email_address_syntax_checker_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// email address syntax checker testbench
// drives addresses byte by byte under random gaps and result back-pressure,
// walks the two length limits through reset, extreme and random settings,
// and leaves verdict checking to the address verdict checker
// ----------------------------------------------------------------------------
module tb_email_address_syntax_checker_unit;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE = 4;
  localparam esc_pkg::cfg_idx_t CFG_UNUSED_LO = esc_pkg::cfg_idx_t'(2);
  localparam esc_pkg::cfg_idx_t CFG_UNUSED_HI = esc_pkg::cfg_idx_t'(255);
  localparam esc_pkg::byte_t CH_BACKTICK = 8'h60;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  esc_pkg::byte_t in_ch;
  logic in_last;
  logic out_valid;
  logic out_ready;
  logic out_valid_res;
  logic cfg_valid;
  logic cfg_ready;
  esc_pkg::cfg_idx_t cfg_index;
  esc_pkg::byte_t cfg_wdata;

  int mismatches;
  int pending;
  int verdicts;
  int valid_verdicts;
  int cycle_count;
  int bytes_sent;
  int addresses_sent;
  int settings_run;
  int cur_local_max;
  int cur_domain_max;
  logic in_burst;
  logic out_burst;
  esc_pkg::byte_t addr_buf[$];
  string local_pool = {"abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ",
                       "0123456789!#$%&'*+-/=?^_{|}~"};
  string domain_pool = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-";

  email_address_syntax_checker_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_ch(in_ch),
    .in_last(in_last),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_valid_res(out_valid_res),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  address_verdict_checker checker_i (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_ch(in_ch),
    .in_last(in_last),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_valid_res(out_valid_res),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .mismatches(mismatches),
    .pending(pending),
    .verdicts(verdicts),
    .valid_verdicts(valid_verdicts)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_email_address_syntax_checker_unit NOT OK");
    $finish;
  end

  // result side back-pressure
  initial begin
    int stall;
    out_ready <= 1'b0;
    out_burst = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 7) == 0) out_burst = ~out_burst;
      stall = out_burst ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      @(negedge clk);
    end
  end

  task automatic send_byte(input esc_pkg::byte_t c, input logic fin);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_ch <= c;
    in_last <= fin;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_buf;
    in_burst = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < addr_buf.size(); i++)
      send_byte(addr_buf[i], i == addr_buf.size() - 1);
    addresses_sent++;
  endtask

  task automatic send_text(input string s);
    addr_buf.delete();
    for (int i = 0; i < s.len(); i++) addr_buf.push_back(s[i]);
    send_buf();
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // leaves cfg_valid high so back-to-back writes need no second assignment
  task automatic write_reg(input esc_pkg::cfg_idx_t idx, input esc_pkg::byte_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    if (idx == esc_pkg::CFG_LOCAL_MAX) cur_local_max = val;
    else if (idx == esc_pkg::CFG_DOMAIN_MAX) cur_domain_max = val;
  endtask

  task automatic set_limits(input int lm, input int dm);
    write_reg(esc_pkg::CFG_LOCAL_MAX, esc_pkg::byte_t'(lm));
    write_reg(esc_pkg::CFG_DOMAIN_MAX, esc_pkg::byte_t'(dm));
    cfg_valid <= 1'b0;
    settings_run++;
  endtask

  function automatic int pick_len(input int m);
    int cap;
    if ($urandom_range(0, 19) == 0 && (m <= 40 || $urandom_range(0, 9) == 0))
      return m + $urandom_range(0, 1);
    cap = (m < 10) ? m : 10;
    if (cap == 0) return $urandom_range(0, 2);
    return $urandom_range(1, cap);
  endfunction

  task automatic build_random;
    int kind;
    int llen;
    int dlen;
    int pos;
    esc_pkg::byte_t c;
    addr_buf.delete();
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      repeat ($urandom_range(1, 6))
        addr_buf.push_back(esc_pkg::byte_t'($urandom_range(0, 255)));
      return;
    end
    llen = pick_len(cur_local_max);
    dlen = pick_len(cur_domain_max);
    for (int i = 0; i < llen; i++) begin
      if (i > 0 && addr_buf[i-1] != esc_pkg::CH_DOT && $urandom_range(0, 7) == 0)
        c = esc_pkg::CH_DOT;
      else if ($urandom_range(0, 39) == 0) c = CH_BACKTICK;
      else c = local_pool[$urandom_range(0, local_pool.len() - 1)];
      addr_buf.push_back(c);
    end
    addr_buf.push_back(esc_pkg::CH_AT);
    for (int i = 0; i < dlen; i++) begin
      if (i > 0 && i < dlen - 1 && addr_buf[$] != esc_pkg::CH_DOT &&
          $urandom_range(0, 4) == 0)
        c = esc_pkg::CH_DOT;
      else c = domain_pool[$urandom_range(0, domain_pool.len() - 1)];
      addr_buf.push_back(c);
    end
    if (kind >= 7) begin
      pos = $urandom_range(0, addr_buf.size() - 1);
      case ($urandom_range(0, 5))
        0: addr_buf[pos] = esc_pkg::byte_t'($urandom_range(0, 255));
        1: addr_buf.insert(pos, esc_pkg::CH_AT);
        2: if (addr_buf.size() > 1) addr_buf.delete(llen);
        3: addr_buf.push_front(esc_pkg::CH_DOT);
        4: begin
          addr_buf.insert(pos, esc_pkg::CH_DOT);
          addr_buf.insert(pos, esc_pkg::CH_DOT);
        end
        default: addr_buf.push_back(esc_pkg::CH_DOT);
      endcase
    end
  endtask

  task automatic run_random(input int budget);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      build_random();
      send_buf();
    end
    drain();
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_ch <= '0;
    in_last <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    in_burst = 1'b0;
    bytes_sent = 0;
    addresses_sent = 0;
    settings_run = 1;
    cur_local_max = esc_pkg::LOCAL_MAX_RST;
    cur_domain_max = esc_pkg::DOMAIN_MAX_RST;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // reset limits: rule corners
    send_text("a@b");
    send_text("@b");
    send_text("ab");
    send_text("a@@b");
    send_text(".a@b");
    send_text("a.@.b");
    send_text("x@y.");
    send_text("a..b@c");
    send_text("a@b..c");
    addr_buf = '{8'hFF, esc_pkg::CH_AT, 8'h62};
    send_buf();
    addr_buf = '{CH_BACKTICK, esc_pkg::CH_AT, 8'h00};
    send_buf();
    send_text("@");
    run_random(60);

    set_limits(1, 1);
    send_text("a@b");
    send_text("ab@c");
    send_text("a@bc");
    run_random(50);

    // widest limits, a local part of 255 bytes and a domain part of 256 bytes
    set_limits(255, 255);
    addr_buf.delete();
    repeat (255) addr_buf.push_back("k");
    addr_buf.push_back(esc_pkg::CH_AT);
    addr_buf.push_back("m");
    send_buf();
    addr_buf.delete();
    addr_buf.push_back("k");
    addr_buf.push_back(esc_pkg::CH_AT);
    repeat (256) addr_buf.push_back("m");
    send_buf();
    run_random(50);
    drain();

    // zero limits and writes to unused indexes
    set_limits(0, 4);
    write_reg(CFG_UNUSED_LO, 8'h00);
    write_reg(CFG_UNUSED_HI, 8'hFF);
    cfg_valid <= 1'b0;
    send_text("a@b");
    send_text("@b");
    run_random(40);

    set_limits(4, 0);
    send_text("a@b");
    send_text("a@");
    run_random(40);

    set_limits(3, 5);
    run_random(50);

    repeat (3) begin
      set_limits($urandom_range(1, 24), $urandom_range(1, 24));
      run_random(40);
    end

    $display("sent %0d bytes in %0d addresses under %0d limit settings",
             bytes_sent, addresses_sent, settings_run);
    $display("checked %0d verdicts, %0d of them valid, %0d mismatches",
             verdicts, valid_verdicts, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("tb_email_address_syntax_checker_unit OK");
    end else begin
      $display("tb_email_address_syntax_checker_unit NOT OK");
    end
    $finish;
  end

endmodule
